/* design/sorted_delay_timer_queue_top_defines.svh */
// assertion helpers used by the timer queue top module
`ifndef SORTED_DELAY_TIMER_QUEUE_TOP_DEFINES_SVH
`define SORTED_DELAY_TIMER_QUEUE_TOP_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define SDTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define SDTQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* design/sdtq_pkg.sv */
package sdtq_pkg;

  localparam int HandleW = 8;
  localparam int DelayW  = 16;
  localparam int KindW   = 3;
  localparam int MaxFire = 16;
  localparam int FIdxW   = $clog2(MaxFire);
  localparam int FCntW   = $clog2(MaxFire + 1);

  typedef enum logic [1:0] {
    ModeInsert = 2'd0,
    ModeRemove = 2'd1,
    ModeExpire = 2'd2
  } mode_e;

  typedef enum logic [KindW-1:0] {
    KindAck   = 3'd0,
    KindArmed = 3'd1,
    KindFired = 3'd2,
    KindFull  = 3'd3,
    KindEmpty = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    OpHold   = 3'd0,
    OpInsert = 3'd1,
    OpPull   = 3'd2,
    OpKill   = 3'd3,
    OpPack   = 3'd4,
    OpSub    = 3'd5
  } cell_op_e;

  typedef enum logic [2:0] {
    StIdle = 3'd0,
    StResp = 3'd1,
    StPack = 3'd2,
    StFire = 3'd3,
    StEmit = 3'd4
  } state_e;

  // broadcast to every cell
  typedef struct packed {
    cell_op_e            op;
    logic [HandleW-1:0]  handle;
    logic [DelayW-1:0]   value;
  } cell_cmd_t;

  // cell contents seen by the right neighbor
  typedef struct packed {
    logic                occ;
    logic                ge;
    logic [HandleW-1:0]  handle;
    logic [DelayW-1:0]   delay;
  } cell_fwd_t;

  // cell contents seen by the left neighbor
  typedef struct packed {
    logic                occ;
    logic [HandleW-1:0]  handle;
    logic [DelayW-1:0]   delay;
  } cell_bwd_t;

endpackage

/* design/sdtq_cell.sv */
module sdtq_cell import sdtq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  cell_fwd_t left_i,
  input  cell_bwd_t right_i,
  output cell_fwd_t fwd_o,
  output cell_bwd_t bwd_o,
  output logic      gap_o
);

  logic               occ_q, occ_d;
  logic [HandleW-1:0] handle_q, handle_d;
  logic [DelayW-1:0]  delay_q, delay_d;
  logic               ge;

  assign ge    = occ_q && (delay_q >= cmd_i.value);
  assign fwd_o = '{occ: occ_q, ge: ge, handle: handle_q, delay: delay_q};
  assign bwd_o = '{occ: occ_q, handle: handle_q, delay: delay_q};
  // an empty slot with an entry to its right still has to close up
  assign gap_o = !occ_q && right_i.occ;

  always_comb begin
    occ_d    = occ_q;
    handle_d = handle_q;
    delay_d  = delay_q;
    case (cmd_i.op)
      OpInsert: begin
        if (left_i.ge) begin
          occ_d    = 1'b1;
          handle_d = left_i.handle;
          delay_d  = left_i.delay;
        end else if (left_i.occ && (!occ_q || ge)) begin
          occ_d    = 1'b1;
          handle_d = cmd_i.handle;
          delay_d  = cmd_i.value;
        end
      end
      OpPull: begin
        occ_d    = right_i.occ;
        handle_d = right_i.handle;
        delay_d  = right_i.delay;
      end
      OpKill: begin
        if (occ_q && (handle_q == cmd_i.handle)) begin
          occ_d = 1'b0;
        end
      end
      OpPack: begin
        if (!occ_q && right_i.occ) begin
          occ_d    = 1'b1;
          handle_d = right_i.handle;
          delay_d  = right_i.delay;
        end else if (occ_q && !left_i.occ) begin
          occ_d = 1'b0;
        end
      end
      OpSub: begin
        delay_d = delay_q - cmd_i.value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    handle_q <= handle_d;
    delay_q  <= delay_d;
  end

endmodule

/* design/sorted_delay_timer_queue_top.sv */
// Sorted timer queue: up to DEPTH pending timers, each a handle and a remaining delay, kept in
// ascending delay order in a row of cells. One item is worked on at a time; in_stall_o is low
// only while the block is idle. An insert or an unused mode is accepted, then the result is
// loaded into the output register. A remove clears every matching cell on accept, then closes
// the holes one cell per cycle until the row is seen packed. An expire fires the due entries,
// at most 16, shifting their handles out of the head cell one by one, subtracts the fired delay
// from the remaining entries, then hands out the fired items, one per cycle while the output is
// not stalled, through the single output register. An expire on an empty queue reports empty.
// A stalled output holds up both the single results and the handout of fired items.
`include "sorted_delay_timer_queue_top_defines.svh"

module sorted_delay_timer_queue_top import sdtq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [HandleW-1:0] handle_i,
  input  logic [DelayW-1:0]  delay_ms_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [KindW-1:0]   kind_o,
  output logic [HandleW-1:0] fired_handle_o,
  output logic [DelayW-1:0]  next_delay_ms_o,
  output logic               busy_res_o,
  output logic               last_o
);

  // cell row
  cell_cmd_t  cmd;
  cell_fwd_t  fwd [DEPTH];
  cell_bwd_t  bwd [DEPTH];
  logic [DEPTH-1:0] gap;
  logic [DEPTH-1:0] occ;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_fwd_t left;
    cell_bwd_t right;
    if (i == 0) begin : g_first
      // virtual occupied cell below every delay
      assign left = '{occ: 1'b1, ge: 1'b0, handle: '0, delay: '0};
    end else begin : g_mid
      assign left = fwd[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '{occ: 1'b0, handle: '0, delay: '0};
    end else begin : g_inner
      assign right = bwd[i+1];
    end
    sdtq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .fwd_o   (fwd[i]),
      .bwd_o   (bwd[i]),
      .gap_o   (gap[i])
    );
    assign occ[i] = fwd[i].occ;
  end

  // control
  state_e             state_q, state_d;
  logic               running_q, running_d;
  kind_e              kind_q, kind_d;
  logic [HandleW-1:0] key_q, key_d;
  logic [DelayW-1:0]  hd_q, hd_d;
  logic [FCntW-1:0]   fcnt_q, fcnt_d;
  logic [HandleW-1:0] fbuf_q [MaxFire];

  // output register
  logic               out_valid_q, out_valid_d;
  logic [KindW-1:0]   okind_q, okind_d;
  logic [HandleW-1:0] ohandle_q, ohandle_d;
  logic [DelayW-1:0]  odelay_q, odelay_d;
  logic               obusy_q, obusy_d;
  logic               olast_q, olast_d;

  logic               accept, out_free, load, push, pop, fire_ok, gap_any;
  logic [DelayW-1:0]  head_delay;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign gap_any    = |gap;
  assign head_delay = fwd[0].occ ? fwd[0].delay : '0;
  // head still due and room left in the fired list
  assign fire_ok    = fwd[0].occ && (fwd[0].delay == hd_q) && (fcnt_q < FCntW'(MaxFire));

  always_comb begin
    state_d   = state_q;
    running_d = running_q;
    kind_d    = kind_q;
    key_d     = key_q;
    hd_d      = hd_q;
    fcnt_d    = fcnt_q;
    cmd       = '{op: OpHold, handle: key_q, value: hd_q};
    load      = 1'b0;
    push      = 1'b0;
    pop       = 1'b0;
    okind_d   = okind_q;
    ohandle_d = ohandle_q;
    odelay_d  = odelay_q;
    obusy_d   = obusy_q;
    olast_d   = olast_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          key_d = handle_i;
          case (mode_e'(mode_i))
            ModeInsert: begin
              state_d = StResp;
              if (occ[DEPTH-1]) begin
                kind_d = KindFull;
              end else begin
                cmd       = '{op: OpInsert, handle: handle_i, value: delay_ms_i};
                kind_d    = running_q ? KindAck : KindArmed;
                running_d = 1'b1;
              end
            end
            ModeRemove: begin
              cmd     = '{op: OpKill, handle: handle_i, value: delay_ms_i};
              kind_d  = KindAck;
              state_d = StPack;
            end
            ModeExpire: begin
              if (!fwd[0].occ) begin
                running_d = 1'b0;
                kind_d    = KindEmpty;
                state_d   = StResp;
              end else begin
                hd_d    = fwd[0].delay;
                fcnt_d  = '0;
                state_d = StFire;
              end
            end
            default: begin
              kind_d  = KindAck;
              state_d = StResp;
            end
          endcase
        end
      end
      StPack: begin
        cmd.op = OpPack;
        if (!gap_any) begin
          state_d = StResp;
        end
      end
      StFire: begin
        if (fire_ok) begin
          cmd.op = OpPull;
          push   = 1'b1;
          fcnt_d = fcnt_q + 1'b1;
        end else begin
          // rebase the remaining entries on the fired delay
          cmd.op    = OpSub;
          running_d = fwd[0].occ;
          state_d   = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          load      = 1'b1;
          pop       = 1'b1;
          okind_d   = KindFired;
          ohandle_d = fbuf_q[0];
          odelay_d  = head_delay;
          obusy_d   = running_q;
          olast_d   = (fcnt_q == FCntW'(1));
          fcnt_d    = fcnt_q - 1'b1;
          if (fcnt_q == FCntW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      StResp: begin
        if (out_free) begin
          load      = 1'b1;
          okind_d   = kind_q;
          ohandle_d = key_q;
          odelay_d  = head_delay;
          obusy_d   = running_q;
          olast_d   = 1'b1;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      running_q   <= 1'b0;
      fcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      fcnt_q      <= fcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    key_q     <= key_d;
    hd_q      <= hd_d;
    okind_q   <= okind_d;
    ohandle_q <= ohandle_d;
    odelay_q  <= odelay_d;
    obusy_q   <= obusy_d;
    olast_q   <= olast_d;
  end

  // fired handles, filled from the head cell and drained in order
  always_ff @(posedge clk_i) begin
    if (push) begin
      fbuf_q[fcnt_q[FIdxW-1:0]] <= fwd[0].handle;
    end else if (pop) begin
      for (int k = 0; k < MaxFire - 1; k++) begin
        fbuf_q[k] <= fbuf_q[k+1];
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = okind_q;
  assign fired_handle_o  = ohandle_q;
  assign next_delay_ms_o = odelay_q;
  assign busy_res_o      = obusy_q;
  assign last_o          = olast_q;

  `SDTQ_ASSERT(a_occ_packed, (state_q == StIdle) |-> ((occ & (occ + DEPTH'(1))) == '0), "occupied cells not packed at head")
  `SDTQ_ASSERT(a_fcnt_bound, fcnt_q <= FCntW'(MaxFire), "fired count beyond limit")
  `SDTQ_ASSERT(a_emit_pending, (state_q == StEmit) |-> (fcnt_q != '0), "emit with no fired handle")
  `SDTQ_ASSERT_NEXT(a_fire_done, (state_q == StFire) && !fire_ok, state_q == StEmit, "fire phase did not hand over")

endmodule

/* verif/tb_sorted_delay_timer_queue_top.sv */
import sdtq_pkg::*;

localparam int QDepth = 16;
localparam logic [1:0] ModeUnused = 2'd3;

typedef struct packed {
  kind_e               kind;
  logic [HandleW-1:0]  handle;
  logic [DelayW-1:0]   next_delay;
  logic                busy;
  logic                last;
} timer_event_t;

// tracks the timer list and the results each accepted item should cause
class timer_event_board;
  logic [HandleW-1:0] slot_handle [QDepth];
  logic [DelayW-1:0]  slot_delay  [QDepth];
  int                 slot_count;
  bit                 running;
  timer_event_t       pending_events [$];
  int unsigned        mismatches;
  int unsigned        results_seen;

  function new();
    slot_count   = 0;
    running      = 1'b0;
    mismatches   = 0;
    results_seen = 0;
  endfunction

  function int unsigned pending();
    return pending_events.size();
  endfunction

  function logic [DelayW-1:0] head_delay();
    return (slot_count > 0) ? slot_delay[0] : '0;
  endfunction

  // result fields come from the list state after the operation
  function void push_event(kind_e kind, logic [HandleW-1:0] handle, bit last);
    timer_event_t ev;
    ev.kind       = kind;
    ev.handle     = handle;
    ev.next_delay = head_delay();
    ev.busy       = running;
    ev.last       = last;
    pending_events.insert(pending_events.size(), ev);
  endfunction

  function void note_request(logic [1:0] mode, logic [HandleW-1:0] handle,
                             logic [DelayW-1:0] delay);
    int                 pos;
    int                 w;
    logic [DelayW-1:0]  head;
    logic [DelayW-1:0]  rem;
    logic [HandleW-1:0] fired [$];
    kind_e              kind;
    case (mode)
      ModeInsert: begin
        if (slot_count >= QDepth) begin
          push_event(KindFull, handle, 1'b1);
        end else begin
          pos = 0;
          while (pos < slot_count && slot_delay[pos] < delay) pos++;
          for (int i = slot_count; i > pos; i--) begin
            slot_handle[i] = slot_handle[i-1];
            slot_delay[i]  = slot_delay[i-1];
          end
          slot_handle[pos] = handle;
          slot_delay[pos]  = delay;
          slot_count++;
          kind    = running ? KindAck : KindArmed;
          running = 1'b1;
          push_event(kind, handle, 1'b1);
        end
      end
      ModeRemove: begin
        w = 0;
        for (int i = 0; i < slot_count; i++) begin
          if (slot_handle[i] != handle) begin
            slot_handle[w] = slot_handle[i];
            slot_delay[w]  = slot_delay[i];
            w++;
          end
        end
        slot_count = w;
        push_event(KindAck, handle, 1'b1);
      end
      ModeExpire: begin
        if (slot_count == 0) begin
          running = 1'b0;
          push_event(KindEmpty, handle, 1'b1);
        end else begin
          head = slot_delay[0];
          w    = 0;
          for (int i = 0; i < slot_count; i++) begin
            rem = slot_delay[i] - head;
            if (rem == 0 && fired.size() < MaxFire) begin
              fired.insert(fired.size(), slot_handle[i]);
            end else begin
              slot_handle[w] = slot_handle[i];
              slot_delay[w]  = rem;
              w++;
            end
          end
          slot_count = w;
          running    = (w > 0);
          foreach (fired[k]) push_event(KindFired, fired[k], k == fired.size() - 1);
        end
      end
      default: begin
        push_event(KindAck, handle, 1'b1);
      end
    endcase
  endfunction

  function void check_event(logic [KindW-1:0] kind, logic [HandleW-1:0] handle,
                            logic [DelayW-1:0] next_delay, logic busy, logic last);
    timer_event_t want;
    results_seen++;
    if (pending_events.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: unexpected result kind %0d handle %0d next %0d busy %0d last %0d",
                 $time, kind, handle, next_delay, busy, last);
      end
      return;
    end
    want = pending_events.pop_front();
    if (kind !== want.kind || handle !== want.handle || next_delay !== want.next_delay ||
        busy !== want.busy || last !== want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: expected kind %0d handle %0d next %0d busy %0d last %0d", $time,
                 want.kind, want.handle, want.next_delay, want.busy, want.last);
        $display("%0t:      got kind %0d handle %0d next %0d busy %0d last %0d", $time,
                 kind, handle, next_delay, busy, last);
      end
    end
  endfunction
endclass

module tb_sorted_delay_timer_queue_top;

  // cycles with no handshake on either side before the run is given up
  localparam int QuietLimit = 4000;
  // long receiver hold-off that backs the queue up into the sender
  localparam int HoldCycles = 300;
  localparam int RandomItems = 290;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         mode_i;
  logic [HandleW-1:0] handle_i;
  logic [DelayW-1:0]  delay_ms_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [KindW-1:0]   kind_o;
  logic [HandleW-1:0] fired_handle_o;
  logic [DelayW-1:0]  next_delay_ms_o;
  logic               busy_res_o;
  logic               last_o;

  timer_event_board board = new();
  int unsigned      quiet_cycles = 0;
  int               burst_left;

  sorted_delay_timer_queue_top #(.DEPTH(QDepth)) u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // sample both handshakes at the rising edge; results checked before new items noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        board.check_event(kind_o, fired_handle_o, next_delay_ms_o, busy_res_o, last_o);
      end
      if (in_valid_i && !in_stall_o) begin
        board.note_request(mode_i, handle_i, delay_ms_i);
      end
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // watchdog: nothing moving for too long means the block is stuck
  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("TB_ERROR");
    $finish;
  end

  // receiver: stall pattern changes in phases, plus one long hold-off
  initial begin
    int unsigned phase_left;
    int unsigned stall_pct;
    int unsigned hold_left;
    bit          held;
    phase_left  = 0;
    stall_pct   = 0;
    hold_left   = 0;
    held        = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && board.results_seen >= 60) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(16, 80);
        case ($urandom_range(2))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          default: stall_pct = 65;
        endcase
      end
      phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // present one item at the falling edge and hold it until taken
  task automatic send_item(logic [1:0] mode, logic [HandleW-1:0] handle,
                           logic [DelayW-1:0] delay);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    handle_i   <= handle;
    delay_ms_i <= delay;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // sender works in bursts; a random gap, sometimes none, opens each new burst
  task automatic offer(logic [1:0] mode, logic [HandleW-1:0] handle,
                       logic [DelayW-1:0] delay);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    send_item(mode, handle, delay);
  endtask

  // sender stops until every outstanding result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    burst_left = 0;
  endtask

  // small handle pool so removes hit and duplicates exist; short delays give ties
  task automatic offer_random(int insert_pct);
    int                 pick;
    logic [1:0]         mode;
    logic [HandleW-1:0] handle;
    logic [DelayW-1:0]  delay;
    pick = $urandom_range(99);
    if (pick < insert_pct) mode = ModeInsert;
    else if (pick < insert_pct + 12) mode = ModeRemove;
    else if (pick < 98) mode = ModeExpire;
    else mode = ModeUnused;
    handle = HandleW'(($urandom_range(3) != 0) ? $urandom_range(7) : $urandom_range(255));
    pick = $urandom_range(9);
    if (pick < 5) delay = DelayW'($urandom_range(15));
    else if (pick < 8) delay = DelayW'($urandom_range(400));
    else delay = DelayW'($urandom_range(65535));
    offer(mode, handle, delay);
  endtask

  initial begin
    int insert_pct;
    insert_pct = 50;
    burst_left = 0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    mode_i     = ModeInsert;
    handle_i   = '0;
    delay_ms_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // expire with nothing queued, unused mode, remove from an empty list
    offer(ModeExpire, 8'h3C, 16'h0000);
    offer(ModeUnused, 8'hFF, 16'hFFFF);
    offer(ModeRemove, 8'h00, 16'h1234);

    // fill all sixteen slots: extreme values, tied delays, a repeated handle
    offer(ModeInsert, 8'h00, 16'hFFFF);
    offer(ModeInsert, 8'hFF, 16'h0000);
    offer(ModeInsert, 8'hA5, 16'd100);
    offer(ModeInsert, 8'h5A, 16'd100);
    offer(ModeInsert, 8'hA5, 16'd100);
    offer(ModeInsert, 8'h01, 16'h0000);
    offer(ModeInsert, 8'h02, 16'd50);
    offer(ModeInsert, 8'h03, 16'hFFFF);
    offer(ModeInsert, 8'h04, 16'd1);
    offer(ModeInsert, 8'h05, 16'd1);
    offer(ModeInsert, 8'h06, 16'd1);
    offer(ModeInsert, 8'h07, 16'd200);
    offer(ModeInsert, 8'h08, 16'd200);
    offer(ModeInsert, 8'h09, 16'h8000);
    offer(ModeInsert, 8'h0A, 16'h7FFF);
    offer(ModeInsert, 8'h0B, 16'h0000);
    // no room left
    offer(ModeInsert, 8'h0C, 16'd5);

    // remove both copies of a handle, then insert while the timer runs
    offer(ModeRemove, 8'hA5, 16'h0000);
    offer(ModeInsert, 8'hC3, 16'd3);
    // several entries due at once, then the next group
    offer(ModeExpire, 8'h00, 16'h0000);
    offer(ModeExpire, 8'h00, 16'h0000);
    // handle not present, unused mode with a busy queue
    offer(ModeRemove, 8'h77, 16'h0000);
    offer(ModeUnused, 8'h81, 16'h00FF);

    wait_drained();

    // random part: insert share changes every few dozen items so the list
    // swings between full and empty
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0:       insert_pct = 85;
          1:       insert_pct = 50;
          default: insert_pct = 30;
        endcase
      end
      if (n == RandomItems / 2) wait_drained();
      offer_random(insert_pct);
    end

    wait_drained();
    // room for any stray result after the last expected one
    repeat (100) @(posedge clk_i);
    @(negedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
